FILE: hdl/vfa_pkg.sv
// Shared types, mode codes and a helper function for the four-lane binary32 vector ALU.
package vfa_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAGES = 8;

  localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_SCALE = 3'd4
  } mode_e;

  // Load enables of the two register stages inside one arithmetic unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } stg_en_t;

  // Bit position of the leading one; zero for a zero word.
  function automatic logic [5:0] lead_pos(input logic [47:0] v);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

FILE: hdl/vec4_float_alu.sv
// Top level: four multiplier and adder lanes plus a two-adder merge chain for the dot product.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o   | mode_i, a_0_i..a_3_i, b_0_i..b_3_i, scalar_i
//   out     | out_valid_o / out_ready_i | r_0_o..r_3_o
//
// One transaction per cycle sustained while out_ready_i is high; the depth is set by the
// chain multiply, lane add and two merge adds that the dot product needs. All modes travel
// the same eight stages. Reset clears only the stage valid bits. Each stage advances when
// it is empty or the one after it advances, so bubbles collapse and a stalled output
// holds only the stages behind it.
module vec4_float_alu
  import vfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] a_0_i,
  input  logic [31:0] a_1_i,
  input  logic [31:0] a_2_i,
  input  logic [31:0] a_3_i,
  input  logic [31:0] b_0_i,
  input  logic [31:0] b_1_i,
  input  logic [31:0] b_2_i,
  input  logic [31:0] b_3_i,
  input  logic [31:0] scalar_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] r_0_o,
  output logic [31:0] r_1_o,
  output logic [31:0] r_2_o,
  output logic [31:0] r_3_o
);

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] adv;
  mode_e             mode_q [STAGES];

  vec_t a_in, b_in, mul_y, a_s0_q, b_s0_q, a_s1_q, b_s1_q;
  vec_t prod, add_x, add_y, sum, prod_s2_q, prod_s3_q, vec_d;
  vec_t vec_q [4:7];
  word_t prod3_s4_q, prod3_s5_q, m1, dot;

  always_comb begin
    adv[STAGES-1] = ~v_q[STAGES-1] | out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) mode_q[0] <= mode_e'(mode_i);
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) mode_q[k] <= mode_q[k-1];
    end
  end

  assign a_in = {a_3_i, a_2_i, a_1_i, a_0_i};
  assign b_in = {b_3_i, b_2_i, b_1_i, b_0_i};

  // Scale mode feeds the scalar to every multiplier lane.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mul_y[i] = (mode_e'(mode_i) == MODE_SCALE) ? scalar_i : b_in[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_s0_q <= a_in;
      b_s0_q <= b_in;
    end
    if (adv[1]) begin
      a_s1_q <= a_s0_q;
      b_s1_q <= b_s0_q;
    end
    if (adv[2]) prod_s2_q <= prod;
    if (adv[3]) prod_s3_q <= prod_s2_q;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vfa_fmul u_mul (
      .clk_i (clk_i),
      .en_i  ('{s1: adv[0], s2: adv[1]}),
      .x_i   (a_in[i]),
      .y_i   (mul_y[i]),
      .z_o   (prod[i])
    );

    vfa_fadd u_add (
      .clk_i (clk_i),
      .en_i  ('{s1: adv[2], s2: adv[3]}),
      .x_i   (add_x[i]),
      .y_i   (add_y[i]),
      .z_o   (sum[i])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      add_x[i] = a_s1_q[i];
      add_y[i] = (mode_q[1] == MODE_SUB) ? {~b_s1_q[i][31], b_s1_q[i][30:0]} : b_s1_q[i];
    end
    // Dot product: lane 0 starts the left-to-right sum of the products.
    if (mode_q[1] == MODE_DOT) begin
      add_x[0] = prod[0];
      add_y[0] = prod[1];
    end
  end

  always_comb begin
    case (mode_q[3])
      MODE_ADD, MODE_SUB:   vec_d = sum;
      MODE_MUL, MODE_SCALE: vec_d = prod_s3_q;
      default:              vec_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      vec_q[4]   <= vec_d;
      prod3_s4_q <= prod_s3_q[3];
    end
    if (adv[5]) begin
      vec_q[5]   <= vec_q[4];
      prod3_s5_q <= prod3_s4_q;
    end
    if (adv[6]) vec_q[6] <= vec_q[5];
    if (adv[7]) vec_q[7] <= vec_q[6];
  end

  vfa_fadd u_merge1 (
    .clk_i (clk_i),
    .en_i  ('{s1: adv[4], s2: adv[5]}),
    .x_i   (sum[0]),
    .y_i   (prod_s3_q[2]),
    .z_o   (m1)
  );

  vfa_fadd u_merge2 (
    .clk_i (clk_i),
    .en_i  ('{s1: adv[6], s2: adv[7]}),
    .x_i   (m1),
    .y_i   (prod3_s5_q),
    .z_o   (dot)
  );

  assign out_valid_o = v_q[STAGES-1];
  assign r_0_o = (mode_q[STAGES-1] == MODE_DOT) ? dot : vec_q[7][0];
  assign r_1_o = vec_q[7][1];
  assign r_2_o = vec_q[7][2];
  assign r_3_o = vec_q[7][3];

endmodule

FILE: hdl/vfa_fmul.sv
// Two-stage binary32 multiplier, round to nearest even, subnormals kept.
module vfa_fmul
  import vfa_pkg::*;
(
  input  logic    clk_i,
  input  stg_en_t en_i,
  input  word_t   x_i,
  input  word_t   y_i,
  output word_t   z_o
);

  logic               sgn_q, nan_q, inf_q;
  logic signed [10:0] e_q;
  logic [47:0]        prod_q;
  word_t              z_q;

  logic               sgn_d, nan_d, inf_d;
  logic signed [10:0] e_d;
  logic [47:0]        prod_d;

  always_comb begin
    logic [7:0]  xe, ye, xee, yee;
    logic        xnan, ynan, xinf, yinf, xzero, yzero;
    logic [23:0] xm, ym;
    xe    = x_i[30:23];
    ye    = y_i[30:23];
    xnan  = (xe == 8'hFF) && (x_i[22:0] != '0);
    ynan  = (ye == 8'hFF) && (y_i[22:0] != '0);
    xinf  = (xe == 8'hFF) && (x_i[22:0] == '0);
    yinf  = (ye == 8'hFF) && (y_i[22:0] == '0);
    xzero = (x_i[30:0] == '0);
    yzero = (y_i[30:0] == '0);
    xm    = {xe != 8'd0, x_i[22:0]};
    ym    = {ye != 8'd0, y_i[22:0]};
    xee   = (xe == 8'd0) ? 8'd1 : xe;
    yee   = (ye == 8'd0) ? 8'd1 : ye;
    sgn_d  = x_i[31] ^ y_i[31];
    nan_d  = xnan | ynan | (xinf & yzero) | (yinf & xzero);
    inf_d  = xinf | yinf;
    e_d    = $signed({3'b000, xee}) + $signed({3'b000, yee}) - 11'sd127;
    prod_d = {24'd0, xm} * {24'd0, ym};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sgn_q  <= sgn_d;
      nan_q  <= nan_d;
      inf_q  <= inf_d;
      e_q    <= e_d;
      prod_q <= prod_d;
    end
  end

  word_t z_d;

  always_comb begin
    logic [5:0]         lp, lmax;
    logic signed [10:0] t, nt, ex;
    logic [6:0]         rs;
    logic [47:0]        pn, low;
    logic               ovf, sticky, inc;
    logic [7:0]         field;
    logic [30:0]        packed_w;
    lp   = lead_pos(prod_q);
    lmax = 6'd47 - lp;
    // Normalize, but stop at the minimum exponent so small results go subnormal.
    if (e_q < $signed({5'b00000, lmax})) t = e_q;
    else t = $signed({5'b00000, lmax});
    nt  = -t;
    rs  = 7'd0;
    low = '0;
    if (!t[10]) begin
      pn = prod_q << t[5:0];
    end else begin
      rs = (nt > 11'sd50) ? 7'd50 : nt[6:0];
      {pn, low} = {prod_q, 48'd0} >> rs;
    end
    ex       = e_q + $signed({5'b00000, lp}) - 11'sd46;
    ovf      = pn[47] && (ex > 11'sd254);
    field    = pn[47] ? ex[7:0] : 8'd0;
    sticky   = (|pn[22:0]) | (|low);
    inc      = pn[23] & (sticky | pn[24]);
    packed_w = {field, pn[46:24]} + {30'd0, inc};
    if (nan_q) z_d = CANON_NAN;
    else if (inf_q || ovf) z_d = {sgn_q, 8'hFF, 23'd0};
    else if (prod_q == '0) z_d = {sgn_q, 31'd0};
    else z_d = {sgn_q, packed_w};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

FILE: hdl/vfa_fadd.sv
// Two-stage binary32 adder, round to nearest even, subnormals kept.
module vfa_fadd
  import vfa_pkg::*;
(
  input  logic    clk_i,
  input  stg_en_t en_i,
  input  word_t   x_i,
  input  word_t   y_i,
  output word_t   z_o
);

  logic        sgn_q, sub_q, nan_q, inf_q, infs_q;
  logic [7:0]  eb_q;
  logic [27:0] sum_q;
  word_t       z_q;

  logic        sgn_d, sub_d, nan_d, inf_d, infs_d;
  logic [7:0]  eb_d;
  logic [27:0] sum_d;

  always_comb begin
    logic        xnan, ynan, xinf, yinf, swap;
    word_t       bg, sm;
    logic [7:0]  se, d;
    logic [5:0]  dc;
    logic [26:0] bm, smm, sh, low, al;
    xnan = (x_i[30:23] == 8'hFF) && (x_i[22:0] != '0);
    ynan = (y_i[30:23] == 8'hFF) && (y_i[22:0] != '0);
    xinf = (x_i[30:23] == 8'hFF) && (x_i[22:0] == '0);
    yinf = (y_i[30:23] == 8'hFF) && (y_i[22:0] == '0);
    // Larger magnitude goes first so the difference never goes negative.
    swap = y_i[30:0] > x_i[30:0];
    bg   = swap ? y_i : x_i;
    sm   = swap ? x_i : y_i;
    eb_d = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    se   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d    = eb_d - se;
    dc   = (d > 8'd28) ? 6'd28 : d[5:0];
    bm   = {bg[30:23] != 8'd0, bg[22:0], 3'b000};
    smm  = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
    {sh, low} = {smm, 27'd0} >> dc;
    al   = sh | {26'd0, |low};
    sub_d  = x_i[31] ^ y_i[31];
    sum_d  = sub_d ? ({1'b0, bm} - {1'b0, al}) : ({1'b0, bm} + {1'b0, al});
    sgn_d  = bg[31];
    nan_d  = xnan | ynan | (xinf & yinf & sub_d);
    inf_d  = xinf | yinf;
    infs_d = xinf ? x_i[31] : y_i[31];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sgn_q  <= sgn_d;
      sub_q  <= sub_d;
      nan_q  <= nan_d;
      inf_q  <= inf_d;
      infs_q <= infs_d;
      eb_q   <= eb_d;
      sum_q  <= sum_d;
    end
  end

  word_t z_d;

  always_comb begin
    logic [5:0]  lp;
    logic [7:0]  la, lsh;
    logic [9:0]  ex;
    logic [26:0] n;
    logic        ovf, inc;
    logic [7:0]  field;
    logic [30:0] packed_w;
    lp  = lead_pos({20'd0, sum_q});
    lsh = 8'd0;
    la  = 8'd0;
    if (lp == 6'd27) begin
      n  = {sum_q[27:2], |sum_q[1:0]};
      ex = {2'b00, eb_q} + 10'd1;
    end else begin
      la  = 8'd26 - {2'b00, lp};
      // Hold the exponent at its floor; the rest stays subnormal.
      lsh = (la < (eb_q - 8'd1)) ? la : (eb_q - 8'd1);
      n   = sum_q[26:0] << lsh;
      ex  = {2'b00, eb_q} - {2'b00, lsh};
    end
    ovf      = n[26] && (ex > 10'd254);
    field    = n[26] ? ex[7:0] : 8'd0;
    inc      = n[2] & (n[1] | n[0] | n[3]);
    packed_w = {field, n[25:3]} + {30'd0, inc};
    if (nan_q) z_d = CANON_NAN;
    else if (inf_q) z_d = {infs_q, 8'hFF, 23'd0};
    else if (sum_q == '0) z_d = {sgn_q & ~sub_q, 31'd0};
    else if (ovf) z_d = {sgn_q, 8'hFF, 23'd0};
    else z_d = {sgn_q, packed_w};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) z_q <= z_d;
  end

  assign z_o = z_q;

endmodule
